// File: rtl/skyline_rectangle_packer_macros.svh
// Assertion helpers for the skyline rectangle packer.
`ifndef SKYLINE_RECTANGLE_PACKER_MACROS_SVH
`define SKYLINE_RECTANGLE_PACKER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define SRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define SRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srp_pkg.sv
package srp_pkg;

    // Request extents and the cell size derived from them
    localparam int EXT_W     = 12;
    localparam int EXT_SHIFT = 4;
    localparam int SIZE_W    = EXT_W - EXT_SHIFT + 1;
    localparam int SIZE_MAX  = 1 << (EXT_W - EXT_SHIFT);

    // Result fields
    localparam int COUNT_W = 16;
    localparam int POS_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [POS_W-1:0]   pos_t;

endpackage

// File: rtl/skyline_rectangle_packer.sv
// Skyline bottom-left rectangle packer. Assert start while busy is low to hand
// in one word (extent_s, extent_t); the block answers with exactly one result,
// shown on block_index, pos_s, pos_t and fail for a single cycle while done is
// high. The receiver cannot hold results off, so capture them on done. After
// reset the block is busy while it clears the first block's height map. A
// rectangle that can never fit is answered at once from idle. Otherwise a
// request opens each block visited and reads column heights in the scan (one
// read of the height RAM per cycle, so the column visits of the bottom-left
// search set the scan's length), then raises the covered columns, or sweeps
// in a fresh block; when no block number is left the answer follows the scan
// directly. Each block visited costs at least one read for every start column
// that is not skipped, and a block whose columns are read in full can take up
// to (BLOCK_W - width) x width reads. busy drops in the cycle done rises.
`include "skyline_rectangle_packer_macros.svh"

module skyline_rectangle_packer #(
    parameter int BLOCK_W       = 128,
    parameter int BLOCK_H       = 128,
    parameter int WINDOW_BLOCKS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [srp_pkg::EXT_W-1:0]   extent_s,
    input  logic [srp_pkg::EXT_W-1:0]   extent_t,
    output logic                        done,
    output logic [srp_pkg::COUNT_W-1:0] block_index,
    output logic [srp_pkg::POS_W-1:0]   pos_s,
    output logic [srp_pkg::POS_W-1:0]   pos_t,
    output logic                        fail
);

    localparam int DEPTH  = WINDOW_BLOCKS * BLOCK_W;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(BLOCK_W);
    localparam int IDX_W  = $clog2(BLOCK_W + 1);
    localparam int HGT_W  = $clog2(BLOCK_H + 1);
    localparam int SLOT_W = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
    localparam int NUM_W  = $clog2(BLOCK_W + BLOCK_H + 2 * srp_pkg::SIZE_MAX) + 1;

    localparam logic [NUM_W-1:0]  BLOCK_W_N = NUM_W'(BLOCK_W);
    localparam logic [NUM_W-1:0]  BLOCK_H_N = NUM_W'(BLOCK_H);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BLOCKS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(BLOCK_W - 1);
    localparam logic [srp_pkg::COUNT_W-1:0] WINDOW_N = srp_pkg::COUNT_W'(WINDOW_BLOCKS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BLK   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;

    // Control state
    logic [2:0]                  state_reg, state_next;
    logic [srp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]           new_slot_reg, new_slot_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [COL_W-1:0]            k_reg, k_next;
    logic                        done_reg, done_next;

    // Request and scan working values
    srp_pkg::size_t              w_reg, w_next;
    srp_pkg::size_t              h_reg, h_next;
    logic [IDX_W-1:0]            i_reg, i_next;
    logic [COL_W-1:0]            j_reg, j_next;
    logic [HGT_W-1:0]            top_reg, top_next;
    logic [HGT_W-1:0]            best_reg, best_next;
    logic [COL_W-1:0]            found_reg, found_next;
    logic [srp_pkg::COUNT_W-1:0] b_reg, b_next;

    // Result word
    logic                        fail_reg, fail_next;
    logic [srp_pkg::COUNT_W-1:0] index_reg, index_next;
    srp_pkg::pos_t               pos_s_reg, pos_s_next;
    srp_pkg::pos_t               pos_t_reg, pos_t_next;

    // Height RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [HGT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [HGT_W-1:0]  ram_rdata;
    logic [COL_W-1:0]  rd_col;

    // Scan decode
    srp_pkg::size_t   w_in, h_in;
    logic [NUM_W-1:0] w_n, h_n, i_n, j_n, c_n, best_n, top_n, top_max;
    logic [NUM_W-1:0] i_cand, best_fin;
    logic             over, blocked, cont;
    logic [SLOT_W-1:0] slot_inc;
    logic [srp_pkg::COUNT_W:0] b_plus;

    srp_ram #(
        .WIDTH(HGT_W),
        .DEPTH(DEPTH)
    ) u_heights (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Convert extents to cell sizes
    assign w_in = srp_pkg::SIZE_W'(extent_s >> srp_pkg::EXT_SHIFT) + srp_pkg::SIZE_W'(1);
    assign h_in = srp_pkg::SIZE_W'(extent_t >> srp_pkg::EXT_SHIFT) + srp_pkg::SIZE_W'(1);

    // Widen scan values for compares
    assign w_n     = NUM_W'(w_reg);
    assign h_n     = NUM_W'(h_reg);
    assign i_n     = NUM_W'(i_reg);
    assign j_n     = NUM_W'(j_reg);
    assign c_n     = NUM_W'(ram_rdata);
    assign best_n  = NUM_W'(best_reg);
    assign top_n   = NUM_W'(top_reg);
    assign top_max = (c_n > top_n) ? c_n : top_n;
    assign over    = (c_n + h_n) > BLOCK_H_N;
    assign blocked = c_n >= best_n;

    assign slot_inc = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
    assign b_plus   = {1'b0, b_reg} + (srp_pkg::COUNT_W + 1)'(1);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        new_slot_next = new_slot_reg;
        slot_next     = slot_reg;
        k_next        = k_reg;
        done_next     = 1'b0;
        w_next        = w_reg;
        h_next        = h_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        top_next      = top_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        b_next        = b_reg;
        fail_next     = fail_reg;
        index_next    = index_reg;
        pos_s_next    = pos_s_reg;
        pos_t_next    = pos_t_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        rd_col        = '0;
        i_cand        = '0;
        cont          = 1'b0;
        best_fin      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero the first block after reset
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(k_reg);
                ram_wdata = '0;
                k_next    = k_reg + COL_W'(1);
                if (k_reg == COL_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    w_next = w_in;
                    h_next = h_in;
                    if (NUM_W'(w_in) >= BLOCK_W_N || NUM_W'(h_in) > BLOCK_H_N)
                    begin
                        // Never fits: answer at once
                        done_next  = 1'b1;
                        fail_next  = 1'b1;
                        index_next = '0;
                        pos_s_next = '0;
                        pos_t_next = '0;
                    end
                    else
                    begin
                        // Begin with the oldest block in the window
                        if (count_reg > WINDOW_N)
                        begin
                            b_next    = count_reg - WINDOW_N;
                            slot_next = new_slot_reg;
                        end
                        else
                        begin
                            b_next    = '0;
                            slot_next = '0;
                        end
                        state_next = ST_BLK;
                    end
                end
            end

            ST_BLK:
            begin
                // Open a block scan at column zero
                best_next  = HGT_W'(BLOCK_H_N - h_n + NUM_W'(1));
                found_next = '0;
                i_next     = '0;
                j_next     = '0;
                top_next   = '0;
                rd_col     = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                // Judge the column just read
                best_fin = best_n;
                if (over)
                begin
                    i_cand = i_n + j_n + NUM_W'(2);
                end
                else if (blocked)
                begin
                    i_cand = i_n + NUM_W'(1);
                end
                else if (j_n + NUM_W'(1) == w_n)
                begin
                    found_next = COL_W'(i_n);
                    best_next  = HGT_W'(top_max);
                    best_fin   = top_max;
                    i_cand     = i_n + NUM_W'(1);
                end
                else
                begin
                    cont     = 1'b1;
                    j_next   = j_reg + COL_W'(1);
                    top_next = HGT_W'(top_max);
                    rd_col   = COL_W'(i_n + j_n + NUM_W'(1));
                end

                if (!cont)
                begin
                    if (i_cand < BLOCK_W_N - w_n)
                    begin
                        // Try the next start column
                        i_next   = IDX_W'(i_cand);
                        j_next   = '0;
                        top_next = '0;
                        rd_col   = COL_W'(i_cand);
                    end
                    else if (best_fin + h_n <= BLOCK_H_N)
                    begin
                        // Place in this block
                        k_next     = '0;
                        state_next = ST_WRITE;
                    end
                    else if (b_plus < {1'b0, count_reg})
                    begin
                        // Advance to the next block in the window
                        b_next     = b_plus[srp_pkg::COUNT_W-1:0];
                        slot_next  = slot_inc;
                        state_next = ST_BLK;
                    end
                    else if (count_reg >= srp_pkg::COUNT_MAX)
                    begin
                        // Out of block numbers
                        done_next  = 1'b1;
                        fail_next  = 1'b1;
                        index_next = '0;
                        pos_s_next = '0;
                        pos_t_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Append a fresh block in the oldest slot
                        b_next        = count_reg;
                        slot_next     = new_slot_reg;
                        count_next    = count_reg + srp_pkg::COUNT_W'(1);
                        new_slot_next = (new_slot_reg == SLOT_LAST) ?
                                        '0 : new_slot_reg + SLOT_W'(1);
                        k_next        = '0;
                        state_next    = ST_SWEEP;
                    end
                end
            end

            ST_WRITE:
            begin
                // Raise the covered columns
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(slot_reg) * ADDR_W'(BLOCK_W)
                          + ADDR_W'(found_reg + k_reg);
                ram_wdata = HGT_W'(best_n + h_n);
                k_next    = k_reg + COL_W'(1);
                if (NUM_W'(k_reg) + NUM_W'(1) == w_n)
                begin
                    done_next  = 1'b1;
                    fail_next  = 1'b0;
                    index_next = b_reg;
                    pos_s_next = srp_pkg::POS_W'(NUM_W'(found_reg));
                    pos_t_next = srp_pkg::POS_W'(best_n);
                    state_next = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                // Clear the fresh block and drop the rectangle at its corner
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(slot_reg) * ADDR_W'(BLOCK_W) + ADDR_W'(k_reg);
                ram_wdata = (NUM_W'(k_reg) < w_n) ? HGT_W'(h_n) : '0;
                k_next    = k_reg + COL_W'(1);
                if (k_reg == COL_LAST)
                begin
                    k_next     = '0;
                    done_next  = 1'b1;
                    fail_next  = 1'b0;
                    index_next = b_reg;
                    pos_s_next = '0;
                    pos_t_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_raddr = ADDR_W'(slot_next) * ADDR_W'(BLOCK_W) + ADDR_W'(rd_col);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            count_reg    <= srp_pkg::COUNT_W'(1);
            new_slot_reg <= (WINDOW_BLOCKS > 1) ? SLOT_W'(1) : '0;
            slot_reg     <= '0;
            k_reg        <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            new_slot_reg <= new_slot_next;
            slot_reg     <= slot_next;
            k_reg        <= k_next;
            done_reg     <= done_next;
        end
    end

    // Hold working values and the result word
    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        h_reg     <= h_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        top_reg   <= top_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        b_reg     <= b_next;
        fail_reg  <= fail_next;
        index_reg <= index_next;
        pos_s_reg <= pos_s_next;
        pos_t_reg <= pos_t_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign fail        = fail_reg;
    assign block_index = index_reg;
    assign pos_s       = pos_s_reg;
    assign pos_t       = pos_t_reg;

    `SRP_ASSERT_NEXT(a_start_answers, clk, rst_n, start && !busy, busy || done, "accepted word neither busy nor answered")
    `SRP_ASSERT_IMPL(a_fail_zero, clk, rst_n, done && fail, block_index == '0 && pos_s == '0 && pos_t == '0, "failed result carries nonzero fields")
    `SRP_ASSERT_IMPL(a_slot_range, clk, rst_n, state_reg == ST_SCAN, slot_reg <= SLOT_LAST && new_slot_reg <= SLOT_LAST, "slot index out of window")
    `SRP_ASSERT_IMPL(a_count_nonzero, clk, rst_n, 1'b1, count_reg != '0, "block count is zero")

endmodule

// File: rtl/srp_ram.sv
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: verif/tb_skyline_rectangle_packer.sv
`timescale 1ns / 100ps

module tb_skyline_rectangle_packer;

    localparam int BLOCK_W       = 128;
    localparam int BLOCK_H       = 128;
    localparam int WINDOW_BLOCKS = 4;
    localparam int CYCLE_LIMIT   = 100_000_000;

    typedef logic [srp_pkg::EXT_W-1:0] extent_t;

    // One placement as the block reports it
    typedef struct packed {
        srp_pkg::count_t blk;
        srp_pkg::pos_t   col;
        srp_pkg::pos_t   row;
        logic            fail;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    extent_t extent_s;
    extent_t extent_t_in;
    logic done;
    srp_pkg::count_t block_index;
    srp_pkg::pos_t pos_s;
    srp_pkg::pos_t pos_t_out;
    logic fail;

    // Predicted skyline of each window slot and number of blocks opened so far
    int skyline [WINDOW_BLOCKS][BLOCK_W];
    int blocks_in_use;

    placement_t expected_placements [$];
    placement_t oldest;
    int mismatches = 0;
    int cycle_count = 0;

    skyline_rectangle_packer #(
        .BLOCK_W      (BLOCK_W),
        .BLOCK_H      (BLOCK_H),
        .WINDOW_BLOCKS(WINDOW_BLOCKS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .extent_s   (extent_s),
        .extent_t   (extent_t_in),
        .done       (done),
        .block_index(block_index),
        .pos_s      (pos_s),
        .pos_t      (pos_t_out),
        .fail       (fail)
    );

    always #2 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timed out with %0d results outstanding", $time,
                     expected_placements.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Find the lowest, then leftmost, spot in one slot. The last start column
    // is never tried, and a column that is too tall skips ahead past itself.
    function automatic bit scan_skyline(input int slot, input int w, input int h,
                                        output int col, output int row);
        int best;
        int i;
        int j;
        int c;
        int top;
        int found;
        best  = BLOCK_H - h + 1;
        found = 0;
        i     = 0;
        while (i < BLOCK_W - w)
        begin
            top = 0;
            for (j = 0; j < w; j++)
            begin
                c = skyline[slot][i + j];
                if (c + h > BLOCK_H)
                begin
                    i += j + 1;
                    break;
                end
                if (c >= best)
                    break;
                if (c > top)
                    top = c;
            end
            if (j == w)
            begin
                found = i;
                best  = top;
            end
            i++;
        end
        col = found;
        row = best;
        return (best + h <= BLOCK_H);
    endfunction

    // Place one rectangle in the predicted skyline and return the placement
    function automatic placement_t predict_placement(input extent_t es, input extent_t et);
        placement_t p;
        int w;
        int h;
        int first;
        int b;
        int col;
        int row;
        int k;
        bit placed;
        p      = '0;
        p.fail = 1'b1;
        w      = int'(es >> srp_pkg::EXT_SHIFT) + 1;
        h      = int'(et >> srp_pkg::EXT_SHIFT) + 1;
        if (w >= BLOCK_W || h > BLOCK_H)
            return p;

        // Try the window, oldest block first
        first  = (blocks_in_use > WINDOW_BLOCKS) ? blocks_in_use - WINDOW_BLOCKS : 0;
        placed = 1'b0;
        for (b = first; b < blocks_in_use; b++)
        begin
            if (scan_skyline(b % WINDOW_BLOCKS, w, h, col, row))
            begin
                placed = 1'b1;
                break;
            end
        end

        // Open a fresh block, dropping the oldest from the window
        if (!placed)
        begin
            if (blocks_in_use >= int'(srp_pkg::COUNT_MAX))
                return p;
            b = blocks_in_use;
            for (k = 0; k < BLOCK_W; k++)
                skyline[b % WINDOW_BLOCKS][k] = 0;
            blocks_in_use++;
            if (!scan_skyline(b % WINDOW_BLOCKS, w, h, col, row))
                return p;
        end

        // Raise the covered columns
        for (k = 0; k < w; k++)
            skyline[b % WINDOW_BLOCKS][col + k] = row + h;

        p.blk  = srp_pkg::count_t'(b);
        p.col  = srp_pkg::pos_t'(col);
        p.row  = srp_pkg::pos_t'(row);
        p.fail = 1'b0;
        return p;
    endfunction

    // Hand in one word and predict its result; start stays high afterwards
    task automatic send_word(input extent_t es, input extent_t et);
        start       <= 1'b1;
        extent_s    <= es;
        extent_t_in <= et;
        do
            @(posedge clk);
        while (busy);
        expected_placements.push_back(predict_placement(es, et));
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold the sender until every predicted result is back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_placements.size() != 0)
            @(posedge clk);
    endtask

    // Mostly small rectangles, some medium, a few over the whole range
    function automatic extent_t random_extent();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return extent_t'($urandom_range(0, 511));
        else if (pick < 9)
            return extent_t'($urandom_range(0, 2047));
        return extent_t'($urandom_range(0, 4095));
    endfunction

    // Field extremes, size limits and the unused last start column
    task automatic test_size_extremes();
        send_word(12'd0, 12'd0);
        send_word(12'hFFF, 12'd0);
        send_word(12'd0, 12'hFFF);
        idle_sender(3);
        send_word(12'd2032, 12'd0);
        send_word(12'd0, 12'd2048);
        send_word(12'd2031, 12'd2047);
        send_word(12'd2016, 12'd2032);
        idle_sender(7);
        send_word(12'd15, 12'd15);
        send_word(12'd2047, 12'd0);
        send_word(12'd0, 12'd2047);
        send_word(12'hAAA, 12'h555);
        send_word(12'h555, 12'h2AA);
        send_word(12'h2AA, 12'h555);
    endtask

    // Leave room in one block, then push it out of the window with full blocks
    task automatic test_window_rollover();
        int n;
        send_word(12'd2031, 12'd1023);
        for (n = 0; n < WINDOW_BLOCKS; n++)
            send_word(12'd2031, 12'd2047);
        idle_sender(1);
        send_word(12'd2031, 12'd1023);
        send_word(12'd0, 12'd0);
    endtask

    task automatic test_random_packing(input int count, input bit with_idle);
        int n;
        bit calm;
        calm = 1'b0;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_word(random_extent(), random_extent());
            if (with_idle && !calm && $urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 11));
        end
    endtask

    // Let the block fall idle between short bursts
    task automatic test_drain_pause();
        int round;
        int n;
        for (round = 0; round < 4; round++)
        begin
            for (n = 0; n < 25; n++)
                send_word(random_extent(), random_extent());
            drain_results();
        end
    endtask

    task automatic test_back_to_back(input int count);
        test_random_packing(count, 1'b0);
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_placements.size() == 0)
            begin
                flag_error($sformatf("unexpected result block_index %0d pos_s %0d pos_t %0d fail %0b",
                                     block_index, pos_s, pos_t_out, fail));
            end
            else
            begin
                oldest = expected_placements.pop_front();
                if (block_index !== oldest.blk)
                    flag_error($sformatf("block_index expected %0d actual %0d",
                                         oldest.blk, block_index));
                if (pos_s !== oldest.col)
                    flag_error($sformatf("pos_s expected %0d actual %0d", oldest.col, pos_s));
                if (pos_t_out !== oldest.row)
                    flag_error($sformatf("pos_t expected %0d actual %0d", oldest.row, pos_t_out));
                if (fail !== oldest.fail)
                    flag_error($sformatf("fail expected %0b actual %0b", oldest.fail, fail));
            end
        end
    end

    initial
    begin
        skyline       = '{default: 0};
        blocks_in_use = 1;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        extent_s    <= '0;
        extent_t_in <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_size_extremes();
        test_window_rollover();
        test_random_packing(500, 1'b1);
        test_drain_pause();
        test_random_packing(325, 1'b1);
        test_back_to_back(225);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_placements.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/srp_pkg.sv
rtl/srp_ram.sv
rtl/skyline_rectangle_packer.sv
verif/tb_skyline_rectangle_packer.sv
